// ===== hdl/tbrl_pkg.sv =====
package tbrl_pkg;

  localparam int FW = 20;
  localparam int TW = 64;
  localparam int PW = 2 * FW;
  localparam int IW = 8;

  localparam logic [FW-1:0] US_PER_SEC  = FW'(1000000);
  localparam logic [FW-1:0] RESET_RATE  = FW'(2000);
  localparam logic [FW-1:0] RESET_CAP   = FW'(200);
  localparam logic [FW-1:0] RESET_COUNT = FW'(200);

  // Two quotient bits are retired per divider step.
  localparam int DIV_STEPS = FW / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [IW-1:0] REG_RATE = IW'(0);
  localparam logic [IW-1:0] REG_CAP  = IW'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAP,
    ST_MUL,
    ST_DLOAD1,
    ST_DIV1,
    ST_YIELD,
    ST_CHECK,
    ST_DLOAD2,
    ST_DIV2,
    ST_ADV,
    ST_GRANT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ELAP,
    OP_MUL,
    OP_DLOAD,
    OP_DSTEP,
    OP_YIELD,
    OP_CLAMP,
    OP_SETCNT,
    OP_ADV,
    OP_GRANT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel_rate;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_blocked;
    logic div_last;
    logic yield_zero;
    logic yield_gt_cap;
  } sts_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [FW:0] div_step(input logic [FW-1:0] rem,
                                           input logic          b,
                                           input logic [FW-1:0] d);
    logic [FW:0] t;
    logic [FW:0] diff;
    t    = {rem, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, diff[FW-1:0]};
    end else begin
      div_step = {1'b0, t[FW-1:0]};
    end
  endfunction

endpackage

// ===== hdl/tbrl_ctrl.sv =====
module tbrl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tbrl_pkg::sts_t sts,
  output tbrl_pkg::cmd_t cmd
);

  tbrl_pkg::state_t state_r;
  tbrl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbrl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = tbrl_pkg::OP_NONE;
    cmd.sel_rate = 1'b0;
    in_stall     = (state_r != tbrl_pkg::ST_IDLE);
    unique case (state_r)
      tbrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = tbrl_pkg::OP_LOAD;
          state_nxt = sts.count_zero ? tbrl_pkg::ST_ELAP : tbrl_pkg::ST_GRANT;
        end
      end
      tbrl_pkg::ST_ELAP: begin
        cmd.op    = tbrl_pkg::OP_ELAP;
        state_nxt = tbrl_pkg::ST_MUL;
      end
      tbrl_pkg::ST_MUL: begin
        cmd.op    = tbrl_pkg::OP_MUL;
        state_nxt = tbrl_pkg::ST_DLOAD1;
      end
      tbrl_pkg::ST_DLOAD1: begin
        cmd.op    = tbrl_pkg::OP_DLOAD;
        state_nxt = tbrl_pkg::ST_DIV1;
      end
      tbrl_pkg::ST_DIV1: begin
        cmd.op = tbrl_pkg::OP_DSTEP;
        if (sts.div_last) begin
          state_nxt = tbrl_pkg::ST_YIELD;
        end
      end
      tbrl_pkg::ST_YIELD: begin
        cmd.op    = tbrl_pkg::OP_YIELD;
        state_nxt = tbrl_pkg::ST_CHECK;
      end
      tbrl_pkg::ST_CHECK: begin
        priority if (sts.yield_zero) begin
          state_nxt = tbrl_pkg::ST_GRANT;
        end else if (sts.yield_gt_cap) begin
          cmd.op    = tbrl_pkg::OP_CLAMP;
          state_nxt = tbrl_pkg::ST_GRANT;
        end else begin
          cmd.op    = tbrl_pkg::OP_SETCNT;
          state_nxt = tbrl_pkg::ST_DLOAD2;
        end
      end
      tbrl_pkg::ST_DLOAD2: begin
        cmd.op       = tbrl_pkg::OP_DLOAD;
        cmd.sel_rate = 1'b1;
        state_nxt    = tbrl_pkg::ST_DIV2;
      end
      tbrl_pkg::ST_DIV2: begin
        cmd.op = tbrl_pkg::OP_DSTEP;
        if (sts.div_last) begin
          state_nxt = tbrl_pkg::ST_ADV;
        end
      end
      tbrl_pkg::ST_ADV: begin
        cmd.op    = tbrl_pkg::OP_ADV;
        state_nxt = tbrl_pkg::ST_GRANT;
      end
      tbrl_pkg::ST_GRANT: begin
        // The result register must be free or draining this cycle.
        if (!sts.out_blocked) begin
          cmd.op    = tbrl_pkg::OP_GRANT;
          state_nxt = tbrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tbrl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tbrl_dp.sv =====
module tbrl_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbrl_pkg::cmd_t                 cmd,
  output tbrl_pkg::sts_t                 sts,
  input  logic [tbrl_pkg::TW-1:0]        in_now_us,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tbrl_pkg::IW-1:0]        cfg_index,
  input  logic [tbrl_pkg::FW-1:0]        cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  output logic [tbrl_pkg::FW-1:0]        out_tokens_left
);

  logic [tbrl_pkg::FW-1:0]    rate_r;
  logic [tbrl_pkg::FW-1:0]    cap_r;
  logic [tbrl_pkg::FW-1:0]    count_r;
  logic [tbrl_pkg::TW-1:0]    stamp_r;
  logic [tbrl_pkg::TW-1:0]    now_r;
  logic                       big_r;
  logic [tbrl_pkg::FW-1:0]    elap_r;
  logic [tbrl_pkg::PW-1:0]    prod_r;
  logic [tbrl_pkg::FW-1:0]    rem_r;
  logic [tbrl_pkg::FW-1:0]    dvd_r;
  logic [tbrl_pkg::FW-1:0]    quo_r;
  logic [tbrl_pkg::FW-1:0]    dsor_r;
  logic [tbrl_pkg::CNT_W-1:0] cnt_r;
  logic [tbrl_pkg::FW-1:0]    yield_r;
  logic                       out_valid_r;
  logic                       out_granted_r;
  logic [tbrl_pkg::FW-1:0]    out_tokens_r;

  logic [tbrl_pkg::TW-1:0]    diff;
  logic [tbrl_pkg::FW:0]      step_hi;
  logic [tbrl_pkg::FW:0]      step_lo;
  logic [tbrl_pkg::FW-1:0]    count_dec;

  assign diff      = now_r - stamp_r;
  assign step_hi   = tbrl_pkg::div_step(rem_r, dvd_r[tbrl_pkg::FW-1], dsor_r);
  assign step_lo   = tbrl_pkg::div_step(step_hi[tbrl_pkg::FW-1:0],
                                        dvd_r[tbrl_pkg::FW-2], dsor_r);
  assign count_dec = count_r - tbrl_pkg::FW'(1);

  assign sts.count_zero   = (count_r == '0);
  assign sts.out_blocked  = out_valid_r && out_stall;
  assign sts.div_last     = (cnt_r == tbrl_pkg::CNT_W'(tbrl_pkg::DIV_STEPS - 1));
  assign sts.yield_zero   = (yield_r == '0) || (rate_r == '0);
  assign sts.yield_gt_cap = (yield_r > cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= tbrl_pkg::RESET_RATE;
      cap_r   <= tbrl_pkg::RESET_CAP;
      count_r <= tbrl_pkg::RESET_COUNT;
      stamp_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tbrl_pkg::REG_RATE) begin
          rate_r <= cfg_data;
        end else if (cfg_index == tbrl_pkg::REG_CAP) begin
          cap_r <= cfg_data;
        end
      end
      unique case (cmd.op)
        tbrl_pkg::OP_LOAD: begin
          now_r <= in_now_us;
        end
        tbrl_pkg::OP_ELAP: begin
          // Wrapped or long gaps count as more than one second.
          big_r  <= (diff > tbrl_pkg::TW'(tbrl_pkg::US_PER_SEC));
          elap_r <= diff[tbrl_pkg::FW-1:0];
        end
        tbrl_pkg::OP_MUL: begin
          prod_r <= tbrl_pkg::PW'(elap_r) * tbrl_pkg::PW'(rate_r);
        end
        tbrl_pkg::OP_DLOAD: begin
          rem_r  <= prod_r[tbrl_pkg::PW-1:tbrl_pkg::FW];
          dvd_r  <= prod_r[tbrl_pkg::FW-1:0];
          quo_r  <= '0;
          dsor_r <= cmd.sel_rate ? rate_r : tbrl_pkg::US_PER_SEC;
          cnt_r  <= '0;
        end
        tbrl_pkg::OP_DSTEP: begin
          rem_r <= step_lo[tbrl_pkg::FW-1:0];
          dvd_r <= {dvd_r[tbrl_pkg::FW-3:0], 2'b00};
          quo_r <= {quo_r[tbrl_pkg::FW-3:0], step_hi[tbrl_pkg::FW], step_lo[tbrl_pkg::FW]};
          cnt_r <= cnt_r + tbrl_pkg::CNT_W'(1);
        end
        tbrl_pkg::OP_YIELD: begin
          yield_r <= big_r ? rate_r : quo_r;
        end
        tbrl_pkg::OP_CLAMP: begin
          count_r <= cap_r;
          stamp_r <= now_r;
        end
        tbrl_pkg::OP_SETCNT: begin
          count_r <= yield_r;
          prod_r  <= tbrl_pkg::PW'(yield_r) * tbrl_pkg::PW'(tbrl_pkg::US_PER_SEC);
        end
        tbrl_pkg::OP_ADV: begin
          // Advance only by the time the credited tokens stand for.
          stamp_r <= stamp_r + tbrl_pkg::TW'(quo_r);
        end
        tbrl_pkg::OP_GRANT: begin
          if (count_r != '0) begin
            count_r <= count_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == tbrl_pkg::OP_GRANT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tbrl_pkg::OP_GRANT) begin
      out_granted_r <= (count_r != '0);
      out_tokens_r  <= (count_r != '0) ? count_dec : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_tokens_left = out_tokens_r;

endmodule

// ===== hdl/token_bucket_rate_limiter_unit.sv =====
// A request goes straight to the grant state when the bucket holds a token; otherwise a
// refill runs first, and it stops after the check when the yield is zero or clamped.
// Requests are taken one at a time: no new request is taken until the last is granted; a
// full refill runs two 10-step divisions (two quotient bits a step) on one shared divider.
// Reset (synchronous, rst_n low): rate 2000, cap 200, 200 tokens, stamp 0, no result.
module token_bucket_rate_limiter_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [tbrl_pkg::TW-1:0] in_now_us,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_granted,
  output logic [tbrl_pkg::FW-1:0] out_tokens_left,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [tbrl_pkg::IW-1:0] cfg_index,
  input  logic [tbrl_pkg::FW-1:0] cfg_data
);

  tbrl_pkg::cmd_t cmd;
  tbrl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tbrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbrl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_now_us       (in_now_us),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted     (out_granted),
    .out_tokens_left (out_tokens_left)
  );

endmodule

// ===== hdl/tbrl_checker.sv =====
module tbrl_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_granted,
  input logic [tbrl_pkg::FW-1:0] out_tokens_left
);

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in progress");

  // A throttled request always reports an empty bucket.
  a_throttle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_tokens_left == '0))
    else $error("throttled result with tokens left");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_granted) && $stable(out_tokens_left)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind token_bucket_rate_limiter_unit tbrl_checker u_tbrl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_granted     (out_granted),
  .out_tokens_left (out_tokens_left)
);
